@@ src/tsp_pkg.sv @@
// Shared types and constants for the tone sequence player.
// Used by tsp_ctrl, tsp_datapath and tone_sequence_player_unit; no dependencies.
package tsp_pkg;

  typedef enum logic [1:0] {
    OP_TICK = 2'd0,
    OP_LOAD = 2'd1,
    OP_PLAY = 2'd2,
    OP_STOP = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    ST_IDLE    = 2'd0,
    ST_FETCH   = 2'd1,
    ST_DIVIDE  = 2'd2,
    ST_RESPOND = 2'd3
  } state_e;

  localparam int unsigned FREQ_W = 15;
  localparam int unsigned DUR_W  = 15;
  localparam int unsigned POS_W  = 9;
  localparam int unsigned DIVS_W = 16;

  // Timer input clock and the lowest frequency that keeps the divisor in 16 bits
  localparam logic [20:0]       PIT_CLOCK = 21'd1193180;
  localparam logic [FREQ_W-1:0] MIN_FREQ  = 15'd19;
  localparam int unsigned       DIV_STEPS = 21;
  localparam int unsigned       DCNT_W    = 5;
  localparam logic [DCNT_W-1:0] DCNT_LAST = 5'(DIV_STEPS - 1);

  typedef struct packed {
    logic exec;      // apply the accepted item
    logic fetch;     // table entry read data is valid, start next note
    logic div_step;  // one quotient bit
  } tsp_cmd_t;

  typedef struct packed {
    logic advance;   // accepted tick moves to the next table entry
    logic rest;      // fetched entry is a rest
    logic div_last;  // final quotient bit this cycle
  } tsp_status_t;

endpackage

@@ src/tsp_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module tsp_ram #(
  parameter int unsigned WIDTH = 30,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/tsp_ctrl.sv @@
// Sequencing state machine of the tone sequence player.
// Depends on tsp_pkg; drives tsp_datapath through tsp_cmd_t.
module tsp_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  input  tsp_pkg::tsp_status_t status_i,
  output tsp_pkg::tsp_cmd_t    cmd_o
);

  tsp_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tsp_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    case (state_q)
      tsp_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.exec = 1'b1;
          state_d    = status_i.advance ? tsp_pkg::ST_FETCH : tsp_pkg::ST_RESPOND;
        end
      end
      tsp_pkg::ST_FETCH: begin
        cmd_o.fetch = 1'b1;
        state_d     = status_i.rest ? tsp_pkg::ST_RESPOND : tsp_pkg::ST_DIVIDE;
      end
      tsp_pkg::ST_DIVIDE: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = tsp_pkg::ST_RESPOND;
        end
      end
      tsp_pkg::ST_RESPOND: begin
        out_valid_o = 1'b1;
        if (!out_stall_i) begin
          state_d = tsp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = tsp_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

@@ src/tsp_datapath.sv @@
// Player state, note table and the restoring divider for the timer divisor.
// Depends on tsp_pkg and tsp_ram; commanded by tsp_ctrl.
module tsp_datapath #(
  parameter int unsigned TABLE_DEPTH = 256
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  tsp_pkg::tsp_cmd_t    cmd_i,
  output tsp_pkg::tsp_status_t status_o,
  input  logic [1:0]           opcode_i,
  input  logic [7:0]           entry_index_i,
  input  logic [14:0]          note_freq_i,
  input  logic [14:0]          note_duration_i,
  input  logic [8:0]           song_length_i,
  output logic                 speaker_gate_o,
  output logic [15:0]          tone_divisor_o,
  output logic                 playing_o,
  output logic [8:0]           note_position_o
);

  localparam int unsigned AW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned ENT_W = tsp_pkg::FREQ_W + tsp_pkg::DUR_W;

  logic                         gate_q, gate_d;
  logic                         active_q, active_d;
  logic [tsp_pkg::POS_W-1:0]    pos_q, pos_d;
  logic [tsp_pkg::POS_W-1:0]    len_q, len_d;
  logic [tsp_pkg::DUR_W-1:0]    ticks_q, ticks_d;
  logic [tsp_pkg::DIVS_W-1:0]   divisor_q, divisor_d;

  // divider: quotient shifts in where the dividend shifts out
  logic [20:0]                  quo_q, quo_d;
  logic [tsp_pkg::FREQ_W-1:0]   rem_q, rem_d;
  logic [tsp_pkg::FREQ_W-1:0]   den_q, den_d;
  logic [tsp_pkg::DCNT_W-1:0]   dcnt_q, dcnt_d;
  logic [tsp_pkg::FREQ_W:0]     trial;
  logic                         qbit;

  logic                         ram_we;
  logic [ENT_W-1:0]             ram_rdata;
  logic [tsp_pkg::FREQ_W-1:0]   ent_freq;
  logic [tsp_pkg::DUR_W-1:0]    ent_dur;
  logic                         song_end;
  tsp_pkg::opcode_e             op;

  assign op       = tsp_pkg::opcode_e'(opcode_i);
  assign ent_freq = ram_rdata[ENT_W-1:tsp_pkg::DUR_W];
  assign ent_dur  = ram_rdata[tsp_pkg::DUR_W-1:0];
  assign song_end = (pos_q >= len_q) || (32'(pos_q) >= TABLE_DEPTH);
  assign ram_we   = cmd_i.exec && (op == tsp_pkg::OP_LOAD) &&
                    (32'(entry_index_i) < TABLE_DEPTH);

  tsp_ram #(
    .WIDTH (ENT_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (AW'(entry_index_i)),
    .wdata_i ({note_freq_i, note_duration_i}),
    .raddr_i (AW'(pos_q)),
    .rdata_o (ram_rdata)
  );

  assign status_o.advance  = (op == tsp_pkg::OP_TICK) && active_q &&
                             (ticks_q == '0) && !song_end;
  assign status_o.rest     = (ent_freq == '0);
  assign status_o.div_last = (dcnt_q == tsp_pkg::DCNT_LAST);

  assign trial = {rem_q, quo_q[20]};
  assign qbit  = (trial >= {1'b0, den_q});

  always_comb begin
    gate_d    = gate_q;
    active_d  = active_q;
    pos_d     = pos_q;
    len_d     = len_q;
    ticks_d   = ticks_q;
    divisor_d = divisor_q;
    quo_d     = quo_q;
    rem_d     = rem_q;
    den_d     = den_q;
    dcnt_d    = dcnt_q;

    if (cmd_i.exec) begin
      case (op)
        tsp_pkg::OP_TICK: begin
          if (active_q) begin
            if (ticks_q != '0) begin
              ticks_d = ticks_q - 1'b1;
            end else if (song_end) begin
              gate_d   = 1'b0;
              active_d = 1'b0;
              pos_d    = '0;
              ticks_d  = '0;
            end
          end
        end
        tsp_pkg::OP_PLAY: begin
          gate_d   = 1'b0;
          len_d    = song_length_i;
          pos_d    = '0;
          ticks_d  = '0;
          active_d = 1'b1;
        end
        tsp_pkg::OP_STOP: begin
          if (active_q) begin
            gate_d   = 1'b0;
            active_d = 1'b0;
          end
        end
        default: begin
          // table load is the RAM write alone
        end
      endcase
    end

    if (cmd_i.fetch) begin
      pos_d   = pos_q + 1'b1;
      ticks_d = ent_dur;
      if (ent_freq == '0) begin
        gate_d = 1'b0;
      end
      quo_d  = tsp_pkg::PIT_CLOCK;
      rem_d  = '0;
      den_d  = (ent_freq < tsp_pkg::MIN_FREQ) ? tsp_pkg::MIN_FREQ : ent_freq;
      dcnt_d = '0;
    end

    if (cmd_i.div_step) begin
      rem_d  = qbit ? tsp_pkg::FREQ_W'(trial - {1'b0, den_q})
                    : tsp_pkg::FREQ_W'(trial);
      quo_d  = {quo_q[19:0], qbit};
      dcnt_d = dcnt_q + 1'b1;
      if (status_o.div_last) begin
        divisor_d = quo_d[15:0];
        gate_d    = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gate_q    <= 1'b0;
      active_q  <= 1'b0;
      pos_q     <= '0;
      len_q     <= '0;
      ticks_q   <= '0;
      divisor_q <= '0;
    end else begin
      gate_q    <= gate_d;
      active_q  <= active_d;
      pos_q     <= pos_d;
      len_q     <= len_d;
      ticks_q   <= ticks_d;
      divisor_q <= divisor_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q  <= quo_d;
    rem_q  <= rem_d;
    den_q  <= den_d;
    dcnt_q <= dcnt_d;
  end

  assign speaker_gate_o  = gate_q;
  assign tone_divisor_o  = divisor_q;
  assign playing_o       = active_q;
  assign note_position_o = pos_q;

endmodule

@@ src/tone_sequence_player_unit.sv @@
// Top level of the tone sequence player: controller plus datapath.
// Depends on tsp_pkg, tsp_ctrl, tsp_datapath and tsp_ram.

// Plays a melody held in a TABLE_DEPTH-entry note table. Each input beat
// (tick, load, play, stop) yields exactly one result beat that shows the
// player state after that beat. The block works on one beat at a time: load,
// play, stop and plain ticks go from acceptance straight to the result; a
// tick that starts a rest first waits for the registered table read, and a
// tick that starts a tone then also runs the one-bit-per-cycle restoring
// division of the timer clock by the note frequency (21 quotient bits). A
// result beat that is held by out_stall_i holds off the next input beat.
// Table entries come up undefined and must be loaded before they are played.
module tone_sequence_player_unit #(
  parameter int unsigned TABLE_DEPTH = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  opcode_i,
  input  logic [7:0]  entry_index_i,
  input  logic [14:0] note_freq_i,
  input  logic [14:0] note_duration_i,
  input  logic [8:0]  song_length_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        speaker_gate_o,
  output logic [15:0] tone_divisor_o,
  output logic        playing_o,
  output logic [8:0]  note_position_o
);

  tsp_pkg::tsp_cmd_t    cmd;
  tsp_pkg::tsp_status_t status;

  tsp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  tsp_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .opcode_i        (opcode_i),
    .entry_index_i   (entry_index_i),
    .note_freq_i     (note_freq_i),
    .note_duration_i (note_duration_i),
    .song_length_i   (song_length_i),
    .speaker_gate_o  (speaker_gate_o),
    .tone_divisor_o  (tone_divisor_o),
    .playing_o       (playing_o),
    .note_position_o (note_position_o)
  );

  // one beat in flight: no input taken while a result is pending
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input accepted while a result is pending");

  // the tone is only ever gated while a song is active
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !playing_o |-> !speaker_gate_o)
    else $error("speaker gated with no active song");

  // gate turns on only at the end of a division, right before the result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(speaker_gate_o) |-> out_valid_o)
    else $error("speaker gate rose outside a result beat");

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for tone_sequence_player_unit: directed table, then random melodies.
// Depends on tsp_pkg and the tone sequence player RTL; keeps its own model of the player.
module tb;

  localparam int unsigned TBL_DEPTH    = 256;
  localparam int unsigned N_DIRECTED   = 26;
  localparam int unsigned RANDOM_BEATS = 700;
  localparam int unsigned HOLD_CYCLES  = 200;
  localparam int unsigned DRAIN_CYCLES = 40;

  typedef struct packed {
    tsp_pkg::opcode_e op;
    logic [7:0]       idx;
    logic [14:0]      freq;
    logic [14:0]      dur;
    logic [8:0]       len;
  } tone_item_t;

  typedef struct packed {
    logic        gate;
    logic [15:0] divisor;
    logic        playing;
    logic [8:0]  pos;
  } tone_state_t;

  typedef struct packed {
    tone_item_t  item;
    logic        chk;
    tone_state_t exp;
  } dir_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [1:0]  opcode_i;
  logic [7:0]  entry_index_i;
  logic [14:0] note_freq_i;
  logic [14:0] note_duration_i;
  logic [8:0]  song_length_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic        speaker_gate_o;
  logic [15:0] tone_divisor_o;
  logic        playing_o;
  logic [8:0]  note_position_o;

  tone_sequence_player_unit #(.TABLE_DEPTH(TBL_DEPTH)) u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .opcode_i        (opcode_i),
    .entry_index_i   (entry_index_i),
    .note_freq_i     (note_freq_i),
    .note_duration_i (note_duration_i),
    .song_length_i   (song_length_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .speaker_gate_o  (speaker_gate_o),
    .tone_divisor_o  (tone_divisor_o),
    .playing_o       (playing_o),
    .note_position_o (note_position_o)
  );

  // Player model state
  logic [14:0] freq_tab [TBL_DEPTH];
  logic [14:0] dur_tab  [TBL_DEPTH];
  bit          loaded   [TBL_DEPTH];
  logic [8:0]  m_pos;
  logic [8:0]  m_len;
  logic [14:0] m_ticks;
  logic        m_active;
  logic        m_gate;
  logic [15:0] m_div;

  tone_state_t expected_states [$];

  int unsigned n_errors;
  int unsigned n_beats;
  int unsigned n_tones;
  int unsigned n_rests;
  int unsigned n_song_ends;
  int unsigned n_restarts;
  bit          calm;
  bit          hold_req;
  int unsigned hold_left;

  // Unused fields carry junk on purpose.
  dir_row_t directed_rows [N_DIRECTED] = '{
    '{'{tsp_pkg::OP_STOP, 8'hFF, 15'h7FFF, 15'h7FFF, 9'h1FF}, 1'b1, '{1'b0, 16'd0, 1'b0, 9'd0}},
    '{'{tsp_pkg::OP_TICK, 8'hFF, 15'h7FFF, 15'h7FFF, 9'h1FF}, 1'b1, '{1'b0, 16'd0, 1'b0, 9'd0}},
    '{'{tsp_pkg::OP_LOAD, 8'd0, 15'd19, 15'd0, 9'h1FF}, 1'b1, '{1'b0, 16'd0, 1'b0, 9'd0}},
    '{'{tsp_pkg::OP_LOAD, 8'd1, 15'd1, 15'd1, 9'h155}, 1'b0, '0},
    '{'{tsp_pkg::OP_LOAD, 8'd2, 15'd0, 15'd0, 9'h0AA}, 1'b0, '0},
    '{'{tsp_pkg::OP_LOAD, 8'd3, 15'd32767, 15'd0, 9'd0}, 1'b0, '0},
    '{'{tsp_pkg::OP_LOAD, 8'd4, 15'd18, 15'd32767, 9'd256}, 1'b0, '0},
    '{'{tsp_pkg::OP_LOAD, 8'd255, 15'd20, 15'd0, 9'd3}, 1'b0, '0},
    '{'{tsp_pkg::OP_PLAY, 8'hFF, 15'h7FFF, 15'h7FFF, 9'd0}, 1'b1, '{1'b0, 16'd0, 1'b1, 9'd0}},
    '{'{tsp_pkg::OP_TICK, 8'h00, 15'h0000, 15'h0000, 9'h000}, 1'b1, '{1'b0, 16'd0, 1'b0, 9'd0}},
    '{'{tsp_pkg::OP_PLAY, 8'h5A, 15'h2AAA, 15'h5555, 9'd511}, 1'b1, '{1'b0, 16'd0, 1'b1, 9'd0}},
    '{'{tsp_pkg::OP_TICK, 8'hFF, 15'h7FFF, 15'h7FFF, 9'h1FF}, 1'b1,
      '{1'b1, 16'd62798, 1'b1, 9'd1}},
    '{'{tsp_pkg::OP_TICK, 8'h00, 15'h0000, 15'h0000, 9'h000}, 1'b0, '0},
    '{'{tsp_pkg::OP_TICK, 8'h00, 15'h0000, 15'h0000, 9'h000}, 1'b0, '0},
    '{'{tsp_pkg::OP_TICK, 8'h00, 15'h0000, 15'h0000, 9'h000}, 1'b0, '0},
    '{'{tsp_pkg::OP_TICK, 8'h00, 15'h0000, 15'h0000, 9'h000}, 1'b1,
      '{1'b1, 16'd36, 1'b1, 9'd4}},
    '{'{tsp_pkg::OP_TICK, 8'h00, 15'h0000, 15'h0000, 9'h000}, 1'b0, '0},
    '{'{tsp_pkg::OP_TICK, 8'h00, 15'h0000, 15'h0000, 9'h000}, 1'b0, '0},
    '{'{tsp_pkg::OP_PLAY, 8'h00, 15'h0000, 15'h0000, 9'd256}, 1'b0, '0},
    '{'{tsp_pkg::OP_STOP, 8'h00, 15'h0000, 15'h0000, 9'h000}, 1'b0, '0},
    '{'{tsp_pkg::OP_STOP, 8'h00, 15'h0000, 15'h0000, 9'h000}, 1'b0, '0},
    '{'{tsp_pkg::OP_PLAY, 8'h00, 15'h0000, 15'h0000, 9'd2}, 1'b0, '0},
    '{'{tsp_pkg::OP_TICK, 8'h00, 15'h0000, 15'h0000, 9'h000}, 1'b0, '0},
    '{'{tsp_pkg::OP_TICK, 8'h00, 15'h0000, 15'h0000, 9'h000}, 1'b0, '0},
    '{'{tsp_pkg::OP_TICK, 8'h00, 15'h0000, 15'h0000, 9'h000}, 1'b0, '0},
    '{'{tsp_pkg::OP_TICK, 8'h00, 15'h0000, 15'h0000, 9'h000}, 1'b0, '0}
  };

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    n_errors++;
  endtask

  // Applies one beat to the model player and returns the state it leaves behind.
  task automatic player_step(input tone_item_t it, output tone_state_t res);
    logic [14:0] f;
    int unsigned fhz;
    case (it.op)
      tsp_pkg::OP_TICK: begin
        if (m_active) begin
          if (m_ticks != 0) begin
            m_ticks--;
          end else if (m_pos >= m_len || m_pos >= TBL_DEPTH) begin
            m_gate   = 1'b0;
            m_active = 1'b0;
            m_pos    = '0;
            m_ticks  = '0;
            n_song_ends++;
          end else begin
            f       = freq_tab[m_pos[7:0]];
            m_ticks = dur_tab[m_pos[7:0]];
            m_pos   = m_pos + 9'd1;
            if (f == '0) begin
              m_gate = 1'b0;
              n_rests++;
            end else begin
              if (f < tsp_pkg::MIN_FREQ) f = tsp_pkg::MIN_FREQ;
              fhz    = f;
              m_div  = 16'(32'(tsp_pkg::PIT_CLOCK) / fhz);
              m_gate = 1'b1;
              n_tones++;
            end
          end
        end
      end
      tsp_pkg::OP_LOAD: begin
        freq_tab[it.idx] = it.freq;
        dur_tab[it.idx]  = it.dur;
        loaded[it.idx]   = 1'b1;
      end
      tsp_pkg::OP_PLAY: begin
        if (m_active) n_restarts++;
        m_gate   = 1'b0;
        m_len    = it.len;
        m_pos    = '0;
        m_ticks  = '0;
        m_active = 1'b1;
      end
      default: begin
        if (m_active) begin
          m_gate   = 1'b0;
          m_active = 1'b0;
        end
      end
    endcase
    res = '{m_gate, m_div, m_active, m_pos};
  endtask

  // Drives one beat, waits for it to be taken, and records what should come back.
  task automatic send_item(input tone_item_t it, input logic chk, input tone_state_t typed);
    tone_state_t pred;
    while (!calm && $urandom_range(0, 99) < 19) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    opcode_i        <= it.op;
    entry_index_i   <= it.idx;
    note_freq_i     <= it.freq;
    note_duration_i <= it.dur;
    song_length_i   <= it.len;
    do @(posedge clk_i); while (in_stall_o);
    player_step(it, pred);
    expected_states.push_back(chk ? typed : pred);
    n_beats++;
  endtask

  function automatic logic [14:0] rand_freq();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 12) return '0;
    if (r < 22) return 15'($urandom_range(1, 19));
    if (r < 25) return 15'h7FFF;
    return 15'($urandom_range(20, 32767));
  endfunction

  function automatic logic [14:0] rand_dur();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 80) return 15'($urandom_range(0, 2));
    if (r < 96) return 15'($urandom_range(3, 30));
    return 15'($urandom);
  endfunction

  // A tick now would fetch a table entry that was never loaded
  function automatic bit needs_unloaded_entry();
    return m_active && m_ticks == 0 && m_pos < m_len && m_pos < TBL_DEPTH
           && !loaded[m_pos[7:0]];
  endfunction

  task automatic make_random_item(output tone_item_t it);
    int unsigned r;
    int unsigned near;
    r  = $urandom_range(0, 99);
    it = '{tsp_pkg::opcode_e'($urandom_range(0, 3)), 8'($urandom), 15'($urandom),
           15'($urandom), 9'($urandom)};
    if (m_active) begin
      it.op = r < 65 ? tsp_pkg::OP_TICK : r < 86 ? tsp_pkg::OP_LOAD :
              r < 94 ? tsp_pkg::OP_PLAY : tsp_pkg::OP_STOP;
    end else begin
      it.op = r < 30 ? tsp_pkg::OP_PLAY : r < 70 ? tsp_pkg::OP_LOAD :
              r < 90 ? tsp_pkg::OP_TICK : tsp_pkg::OP_STOP;
    end
    if (it.op == tsp_pkg::OP_LOAD) begin
      near = m_pos + $urandom_range(0, 3);
      if ($urandom_range(0, 99) < 60) it.idx = near > 255 ? 8'd255 : 8'(near);
      it.freq = rand_freq();
      it.dur  = rand_dur();
    end
    if (it.op == tsp_pkg::OP_PLAY) begin
      r = $urandom_range(0, 99);
      it.len = r < 70 ? 9'($urandom_range(0, 16)) : r < 85 ? 9'($urandom_range(17, 255)) :
               r < 95 ? 9'd256 : 9'($urandom_range(257, 511));
    end
    if (it.op == tsp_pkg::OP_TICK && needs_unloaded_entry()) begin
      it.op   = tsp_pkg::OP_LOAD;
      it.idx  = m_pos[7:0];
      it.freq = rand_freq();
      it.dur  = rand_dur();
    end
  endtask

  // Result side: checks each beat and plays the stall pattern
  always @(posedge clk_i) begin : result_check
    tone_state_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_states.size() == 0) begin
        report_mismatch("result beat with nothing expected");
      end else begin
        want = expected_states.pop_front();
        if (speaker_gate_o !== want.gate)
          report_mismatch($sformatf("speaker_gate %0b, want %0b", speaker_gate_o, want.gate));
        if (tone_divisor_o !== want.divisor)
          report_mismatch($sformatf("tone_divisor %0d, want %0d", tone_divisor_o,
                                    want.divisor));
        if (playing_o !== want.playing)
          report_mismatch($sformatf("playing %0b, want %0b", playing_o, want.playing));
        if (note_position_o !== want.pos)
          report_mismatch($sformatf("note_position %0d, want %0d", note_position_o, want.pos));
      end
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (hold_req) begin
      hold_req    = 1'b0;
      hold_left   = HOLD_CYCLES;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= !calm && $urandom_range(0, 99) < 19;
    end
  end

  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin : stimulus
    tone_item_t  it;
    int unsigned useful;
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    opcode_i        = '0;
    entry_index_i   = '0;
    note_freq_i     = '0;
    note_duration_i = '0;
    song_length_i   = '0;
    out_stall_i     = 1'b0;
    calm            = 1'b0;
    hold_req        = 1'b0;
    hold_left       = 0;
    n_errors        = 0;
    n_beats         = 0;
    n_tones         = 0;
    n_rests         = 0;
    n_song_ends     = 0;
    n_restarts      = 0;
    m_pos           = '0;
    m_len           = '0;
    m_ticks         = '0;
    m_active        = 1'b0;
    m_gate          = 1'b0;
    m_div           = '0;
    for (int i = 0; i < TBL_DEPTH; i++) begin
      freq_tab[i] = '0;
      dur_tab[i]  = '0;
      loaded[i]   = 1'b0;
    end
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < N_DIRECTED; i++)
      send_item(directed_rows[i].item, directed_rows[i].chk, directed_rows[i].exp);

    // Whole-table song: fill every entry, then play it to the end
    for (int i = 0; i < TBL_DEPTH; i++) begin
      it = '{tsp_pkg::OP_LOAD, 8'(i), rand_freq(), 15'($urandom_range(0, 1)), 9'($urandom)};
      send_item(it, 1'b0, '0);
    end
    send_item('{tsp_pkg::OP_PLAY, 8'($urandom), 15'($urandom), 15'($urandom), 9'd256},
              1'b0, '0);
    while (m_active)
      send_item('{tsp_pkg::OP_TICK, 8'($urandom), 15'($urandom), 15'($urandom),
                  9'($urandom)}, 1'b0, '0);

    useful = 0;
    while (useful < RANDOM_BEATS) begin
      if (useful == 50) hold_req = 1'b1;
      calm = useful >= 300 && useful < 450;
      make_random_item(it);
      if (m_active || !(it.op inside {tsp_pkg::OP_TICK, tsp_pkg::OP_STOP})) useful++;
      send_item(it, 1'b0, '0);
    end
    calm = 1'b0;
    in_valid_i <= 1'b0;

    while (expected_states.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (expected_states.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_states.size()));

    $display("Run: %0d beats, %0d tones and %0d rests started, %0d songs ran out,",
             n_beats, n_tones, n_rests, n_song_ends);
    $display("     %0d songs restarted mid-play, %0d mismatches", n_restarts, n_errors);
    if (n_errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
